FILE: rtl/core/bkl_pkg.sv
// ============================================================================
// Bakery lock package
// Transaction payload types and the control bundle shared by the lock cells.
// ============================================================================
package bkl_pkg;

  // Reset value of the label limit register.
  localparam logic [31:0] LabelLimitReset = 32'd2847483647;

  typedef enum logic {
    ACT_REQUEST = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [2:0] requester;
  } cmd_t;

  typedef struct packed {
    logic        holder_valid;
    logic [2:0]  holder_id;
    logic [31:0] ticket;
    logic        status;
  } res_t;

  // Control bundle broadcast from the sequencer to every cell.
  typedef struct packed {
    logic sel_valid;     // The selected requester id names an existing cell.
    logic upd_we;        // Write the selected cell's state this cycle.
    logic upd_set_label; // Also load a new label.
    logic upd_interest;  // New interest flag.
  } cell_ctrl_t;

endpackage

FILE: rtl/core/bkl_cell.sv
// ============================================================================
// Bakery lock cell
// Holds one requester's interest flag and label and folds them into the
// running scan result that it receives from its left neighbor.
// ============================================================================
module bkl_cell import bkl_pkg::*; #(
  parameter int LABEL_BITS = 32,
  parameter int ID_BITS    = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ID_BITS-1:0]    my_id_i,
  input  logic [ID_BITS-1:0]    sel_id_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [LABEL_BITS-1:0] upd_label_i,
  // Running scan result from the left neighbor.
  input  logic [LABEL_BITS-1:0] max_i,
  input  logic                  found_i,
  input  logic [LABEL_BITS-1:0] best_label_i,
  input  logic [ID_BITS-1:0]    best_id_i,
  input  logic [LABEL_BITS-1:0] sel_label_i,
  input  logic                  sel_int_i,
  // Running scan result handed to the right neighbor.
  output logic [LABEL_BITS-1:0] max_o,
  output logic                  found_o,
  output logic [LABEL_BITS-1:0] best_label_o,
  output logic [ID_BITS-1:0]    best_id_o,
  output logic [LABEL_BITS-1:0] sel_label_o,
  output logic                  sel_int_o
);

  logic                  int_q;
  logic [LABEL_BITS-1:0] label_q;
  logic                  mine;
  logic                  take;

  logic [LABEL_BITS-1:0] max_q, best_label_q, sel_label_q;
  logic                  found_q, sel_int_q;
  logic [ID_BITS-1:0]    best_id_q;

  assign mine = ctrl_i.sel_valid && (sel_id_i == my_id_i);
  // The selected requester is left out of the holder scan; the sequencer
  // weighs it separately with its post-update state.
  assign take = int_q && !mine && (!found_i || (label_q < best_label_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q   <= 1'b0;
      label_q <= '0;
    end else if (ctrl_i.upd_we && mine) begin
      int_q <= ctrl_i.upd_interest;
      if (ctrl_i.upd_set_label) begin
        label_q <= upd_label_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    max_q        <= (label_q > max_i) ? label_q : max_i;
    found_q      <= found_i || take;
    best_label_q <= take ? label_q : best_label_i;
    best_id_q    <= take ? my_id_i : best_id_i;
    sel_label_q  <= mine ? label_q : sel_label_i;
    sel_int_q    <= mine ? int_q : sel_int_i;
  end

  assign max_o        = max_q;
  assign found_o      = found_q;
  assign best_label_o = best_label_q;
  assign best_id_o    = best_id_q;
  assign sel_label_o  = sel_label_q;
  assign sel_int_o    = sel_int_q;

endmodule

FILE: rtl/core/bakery_ticket_lock_arbiter.sv
// ============================================================================
// Bakery ticket lock arbiter
// Lamport bakery lock over a row of per-requester cells with one sequencer.
// ============================================================================
// Usage: pulse start with a transaction on cmd_i while busy is low. A request
// draws a ticket one above the largest label held and marks the requester
// interested; a release clears its interest flag. Every transaction yields
// exactly one result on res_o, shown for a single cycle with res_valid_o high.
// The result names the lock holder (smallest label, ties to the smaller id),
// the requester's current label and a status bit that flags a refused request.
// The scan result is registered in each of the REQUESTERS cells in turn.
// When it reaches the chain tail, the selected cell's state and the result
// register are written at the same edge; busy drops in that last scan cycle,
// so a new transaction can be taken at that edge, but none while one is
// still in flight. The receiver cannot stall; a result is lost if not
// captured in its strobe cycle. Reset clears all interest flags and labels and
// loads the label limit with its default. cfg_wdata_i is written into the
// label limit at any edge where cfg_we_i is high, normally while idle.
// ============================================================================
module bakery_ticket_lock_arbiter import bkl_pkg::*; #(
  parameter int REQUESTERS = 8,
  parameter int LABEL_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int IdBits  = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CntBits = $clog2(REQUESTERS + 1);
  localparam int CmpBits = LABEL_BITS + 32;

  // Sequencer state.
  logic               busy_q;
  logic [CntBits-1:0] cnt_q;
  cmd_t               cmd_q;
  logic [31:0]        limit_q;
  logic               accept;
  logic               last_cycle;

  // Scan chain wiring; entry k feeds cell k, entry REQUESTERS is the result.
  logic [LABEL_BITS-1:0] max_w        [REQUESTERS+1];
  logic                  found_w      [REQUESTERS+1];
  logic [LABEL_BITS-1:0] best_label_w [REQUESTERS+1];
  logic [IdBits-1:0]     best_id_w    [REQUESTERS+1];
  logic [LABEL_BITS-1:0] sel_label_w  [REQUESTERS+1];
  logic                  sel_int_w    [REQUESTERS+1];

  cell_ctrl_t            ctrl;
  logic [IdBits+2:0]     who_ext;
  logic                  in_range;
  logic [IdBits-1:0]     r_idx;
  logic [LABEL_BITS-1:0] scan_max, old_label, new_label, cand_label;
  logic                  is_req, refused, cand_valid, cand_wins;
  logic [CmpBits-1:0]    old_ext, limit_ext;
  logic [LABEL_BITS-1:0] ticket_label;
  logic [LABEL_BITS+31:0] ticket_pad;
  logic [IdBits+2:0]     best_pad;
  res_t                  res_d, res_q;
  logic                  res_valid_q;

  assign last_cycle = busy_q && (cnt_q == CntBits'(REQUESTERS));
  assign busy       = busy_q && !last_cycle;
  assign accept     = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      limit_q     <= LabelLimitReset;
    end else begin
      res_valid_q <= last_cycle;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (last_cycle) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (last_cycle) begin
      res_q <= res_d;
    end
  end

  // Requester decode; an id beyond the cell count selects no cell.
  assign who_ext  = {{IdBits{1'b0}}, cmd_q.requester};
  assign in_range = who_ext < (IdBits + 3)'(REQUESTERS);
  assign r_idx    = who_ext[IdBits-1:0];

  // Chain head: empty scan result.
  assign max_w[0]        = '0;
  assign found_w[0]      = 1'b0;
  assign best_label_w[0] = '0;
  assign best_id_w[0]    = '0;
  assign sel_label_w[0]  = '0;
  assign sel_int_w[0]    = 1'b0;

  for (genvar k = 0; k < REQUESTERS; k++) begin : g_cell
    bkl_cell #(
      .LABEL_BITS(LABEL_BITS),
      .ID_BITS   (IdBits)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .my_id_i     (IdBits'(k)),
      .sel_id_i    (r_idx),
      .ctrl_i      (ctrl),
      .upd_label_i (new_label),
      .max_i       (max_w[k]),
      .found_i     (found_w[k]),
      .best_label_i(best_label_w[k]),
      .best_id_i   (best_id_w[k]),
      .sel_label_i (sel_label_w[k]),
      .sel_int_i   (sel_int_w[k]),
      .max_o       (max_w[k+1]),
      .found_o     (found_w[k+1]),
      .best_label_o(best_label_w[k+1]),
      .best_id_o   (best_id_w[k+1]),
      .sel_label_o (sel_label_w[k+1]),
      .sel_int_o   (sel_int_w[k+1])
    );
  end

  // Final step: the tail of the chain holds the largest label, the best
  // holder among the other requesters, and the selected requester's state.
  assign scan_max  = max_w[REQUESTERS];
  assign old_label = sel_label_w[REQUESTERS];
  assign is_req    = (cmd_q.action == ACT_REQUEST);
  assign old_ext   = {32'd0, old_label};
  assign limit_ext = {{LABEL_BITS{1'b0}}, limit_q};
  assign refused   = in_range && is_req && (old_ext > limit_ext);
  // The next ticket saturates at the all-ones label.
  assign new_label = (&scan_max) ? scan_max : scan_max + 1'b1;

  always_comb begin
    ctrl.sel_valid     = in_range;
    ctrl.upd_we        = last_cycle && in_range && !refused;
    ctrl.upd_set_label = is_req;
    ctrl.upd_interest  = is_req;
  end

  // The selected requester competes for the lock with its state after the
  // update: a new ticket when granted, its old state when refused, and not
  // at all after a release.
  always_comb begin
    cand_valid   = 1'b0;
    cand_label   = old_label;
    ticket_label = '0;
    if (in_range) begin
      ticket_label = old_label;
      if (is_req) begin
        if (refused) begin
          cand_valid = sel_int_w[REQUESTERS];
        end else begin
          cand_valid   = 1'b1;
          cand_label   = new_label;
          ticket_label = new_label;
        end
      end
    end
  end

  assign cand_wins = cand_valid && (!found_w[REQUESTERS] ||
                     (cand_label < best_label_w[REQUESTERS]) ||
                     ((cand_label == best_label_w[REQUESTERS]) &&
                      (r_idx < best_id_w[REQUESTERS])));

  assign ticket_pad = {32'd0, ticket_label};
  assign best_pad   = {3'd0, best_id_w[REQUESTERS]};

  always_comb begin
    res_d.holder_valid = cand_wins || found_w[REQUESTERS];
    if (cand_wins) begin
      res_d.holder_id = cmd_q.requester;
    end else if (found_w[REQUESTERS]) begin
      res_d.holder_id = best_pad[2:0];
    end else begin
      res_d.holder_id = 3'd0;
    end
    res_d.ticket = ticket_pad[31:0];
    res_d.status = refused;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: tb/bakery_ticket_lock_arbiter_tb.sv
// ============================================================================
// Bakery ticket lock arbiter testbench
// Drives request and release transactions into the lock arbiter under several
// label limit settings and checks every result against a cycle-free model of
// the bakery lock state kept inside the bench, or against a hand-typed result.
// ============================================================================
module bakery_ticket_lock_arbiter_tb;
  import bkl_pkg::*;

  localparam int REQUESTERS = 8;
  localparam int LABEL_BITS = 32;
  // Generous upper bound on the run, in clock cycles of 20 time units.
  localparam int TIMEOUT_CYCLES = 250000;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int PHASES = 6;
  localparam int SHOWN_MISMATCHES = 10;

  // One row of the directed table: either a label limit write or a
  // transaction, optionally with its result typed in by hand.
  typedef struct {
    bit          is_cfg;
    logic [31:0] cfg_val;
    cmd_t        cmd;
    bit          typed;
    res_t        want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // Bench copy of the lock state: interest flags, labels and the limit.
  bit          want_q  [REQUESTERS];
  logic [31:0] label_q [REQUESTERS];
  logic [31:0] limit_q;

  // Results still owed by the arbiter, oldest first.
  res_t        pending_grants[$];
  row_t        directed_rows[$];

  int          errors;
  int          mismatches;
  int          results_seen;
  int          n_request;
  int          n_release;
  int          n_refused;
  int          n_settings;
  bit          gaps_on;

  bakery_ticket_lock_arbiter #(
    .REQUESTERS (REQUESTERS),
    .LABEL_BITS (LABEL_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // The lock holder is the interested requester with the smallest label.
  // The strict compare keeps the first, and so the smaller, id on a tie.
  function automatic void lock_holder(output bit found, output logic [2:0] id);
    int best;
    found = 1'b0;
    best  = 0;
    for (int k = 0; k < REQUESTERS; k++) begin
      if (want_q[k] && (!found || label_q[k] < label_q[best])) begin
        found = 1'b1;
        best  = k;
      end
    end
    id = found ? best[2:0] : 3'd0;
  endfunction

  // Applies one transaction to the bench state and returns the result the
  // arbiter must report for it.
  function automatic res_t bakery_next(input cmd_t c);
    res_t        r;
    logic [31:0] top;
    int          who;
    bit          found;
    logic [2:0]  hid;
    r   = '0;
    who = int'(c.requester);
    if (c.action == ACT_REQUEST) begin
      if (label_q[who] > limit_q) begin
        // An old label above the limit freezes the requester: nothing moves.
        r.status = 1'b1;
      end else begin
        top = '0;
        for (int k = 0; k < REQUESTERS; k++) begin
          if (label_q[k] > top) top = label_q[k];
        end
        // The next ticket saturates at the all-ones label.
        if (top != '1) top = top + 32'd1;
        label_q[who] = top;
        want_q[who]  = 1'b1;
      end
    end else begin
      want_q[who] = 1'b0;
    end
    r.ticket = label_q[who];
    lock_holder(found, hid);
    r.holder_valid = found;
    r.holder_id    = hid;
    return r;
  endfunction

  task automatic add_cmd(input action_e act, input logic [2:0] who);
    row_t row;
    row = '{default: '0};
    row.cmd.action    = act;
    row.cmd.requester = who;
    directed_rows.push_back(row);
  endtask

  task automatic add_typed(input action_e act, input logic [2:0] who, input logic hv,
                           input logic [2:0] hid, input logic [31:0] tk, input logic st);
    row_t row;
    row = '{default: '0};
    row.cmd.action        = act;
    row.cmd.requester     = who;
    row.typed             = 1'b1;
    row.want.holder_valid = hv;
    row.want.holder_id    = hid;
    row.want.ticket       = tk;
    row.want.status       = st;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [31:0] v);
    row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    directed_rows.push_back(row);
  endtask

  // Label limit writes happen only once every owed result has come back, so
  // the arbiter is idle. Every transaction yields a result, so an empty queue
  // means nothing is left in flight.
  task automatic write_limit(input logic [31:0] v);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we  <= 1'b0;
    limit_q = v;
    n_settings++;
  endtask

  // Offers one transaction and holds it until the arbiter takes it. The
  // caller always stands at a falling edge; on return the bench is again at
  // a falling edge with start still high, so back-to-back transactions need
  // only one assignment to start per time step.
  task automatic issue(input cmd_t c, input bit typed, input res_t want);
    res_t model;
    bit   taken;
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd   <= c;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (!busy) begin
        // Accepted at this edge: the model steps in acceptance order.
        model = bakery_next(c);
        pending_grants.push_back(typed ? want : model);
        taken = 1'b1;
        if (c.action == ACT_REQUEST) n_request++;
        else n_release++;
        if (model.status) n_refused++;
      end
      @(negedge clk_i);
    end
  endtask

  // Result checker. The strobe lasts one cycle and cannot be held off, so
  // each rising edge with the strobe high consumes exactly one expectation.
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_valid_o === 1'b1) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        errors++;
        $display("ERROR: result with no transaction pending: valid=%0b id=%0d ticket=%0d st=%0b",
                 res_o.holder_valid, res_o.holder_id, res_o.ticket, res_o.status);
      end else begin
        exp_r = pending_grants.pop_front();
        if (res_o.holder_valid !== exp_r.holder_valid || res_o.holder_id !== exp_r.holder_id ||
            res_o.ticket !== exp_r.ticket || res_o.status !== exp_r.status) begin
          errors++;
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES) begin
            $display("MISMATCH at result %0d: expected valid=%0b id=%0d ticket=%0d st=%0b",
                     results_seen, exp_r.holder_valid, exp_r.holder_id, exp_r.ticket,
                     exp_r.status);
            $display("                         actual valid=%0b id=%0d ticket=%0d st=%0b",
                     res_o.holder_valid, res_o.holder_id, res_o.ticket, res_o.status);
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("ERROR: timeout with %0d results still owed", pending_grants.size());
    $display("** bakery_ticket_lock_arbiter: FAILED **");
    $finish;
  end

  initial begin
    cmd_t        c;
    res_t        none;
    bit          found;
    logic [2:0]  hid;
    logic [2:0]  pick;
    logic [31:0] top;
    logic [31:0] lim;
    int          guard;

    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_ni    = 1'b0;
    none      = '0;
    errors    = 0;
    gaps_on   = 1'b1;
    for (int k = 0; k < REQUESTERS; k++) begin
      want_q[k]  = 1'b0;
      label_q[k] = '0;
    end
    limit_q = LabelLimitReset;

    // Directed part, starting from the reset limit. Hand-typed results are
    // the ones that follow straight from the reset state or from the limit.
    add_typed(ACT_RELEASE, 3'd0, 1'b0, 3'd0, 32'd0, 1'b0); // release while not interested
    add_typed(ACT_REQUEST, 3'd7, 1'b1, 3'd7, 32'd1, 1'b0); // first ticket after reset
    add_cmd(ACT_REQUEST, 3'd0);
    add_cmd(ACT_REQUEST, 3'd7);                            // repeated request, fresh ticket
    add_cmd(ACT_RELEASE, 3'd0);
    add_typed(ACT_RELEASE, 3'd7, 1'b0, 3'd0, 32'd3, 1'b0); // last holder leaves
    add_typed(ACT_RELEASE, 3'd7, 1'b0, 3'd0, 32'd3, 1'b0); // release twice
    add_cfg(32'd0);                                        // lowest limit
    add_typed(ACT_REQUEST, 3'd3, 1'b1, 3'd3, 32'd4, 1'b0); // old label zero still passes
    add_typed(ACT_REQUEST, 3'd7, 1'b1, 3'd3, 32'd3, 1'b1); // label over the limit
    add_typed(ACT_REQUEST, 3'd3, 1'b1, 3'd3, 32'd4, 1'b1); // holder refused too
    add_cmd(ACT_RELEASE, 3'd3);
    add_cfg(32'hFFFF_FFFF);                                // highest limit
    add_cmd(ACT_REQUEST, 3'd1);
    add_cmd(ACT_REQUEST, 3'd2);
    add_cmd(ACT_REQUEST, 3'd4);
    add_cmd(ACT_REQUEST, 3'd5);
    add_cmd(ACT_REQUEST, 3'd6);
    add_cmd(ACT_REQUEST, 3'd0);
    add_cmd(ACT_RELEASE, 3'd1);
    add_cmd(ACT_RELEASE, 3'd5);
    add_cfg(32'd4);                                        // only requesters 3 and 7 fit
    add_cmd(ACT_REQUEST, 3'd3);
    add_cmd(ACT_REQUEST, 3'd3);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_limit(directed_rows[i].cfg_val);
      else issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part. Each phase picks a limit, then mostly plays the lock the
    // way threads use it (free requesters ask, the holder leaves) with some
    // plain random transactions mixed in.
    for (int p = 0; p < PHASES; p++) begin
      top = '0;
      for (int k = 0; k < REQUESTERS; k++) begin
        if (label_q[k] > top) top = label_q[k];
      end
      case (p)
        0:       lim = LabelLimitReset;
        1:       lim = 32'hFFFF_FFFF;
        2:       lim = top - 32'($urandom_range(0, 8));    // most requesters refused
        3:       lim = top + 32'($urandom_range(20, 120)); // refusals set in mid phase
        4:       lim = 32'd0;
        default: lim = $urandom;
      endcase
      write_limit(lim);
      // One phase runs without any sender gaps at all.
      gaps_on = (p != 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(3) != 0) begin
          lock_holder(found, hid);
          pick = 3'($urandom_range(0, 7));
          for (int t = 0; t < REQUESTERS && want_q[pick]; t++) pick = pick + 3'd1;
          if (found && ($urandom_range(99) < 40 || want_q[pick])) begin
            c.action    = ACT_RELEASE;
            c.requester = hid;
          end else begin
            c.action    = ACT_REQUEST;
            c.requester = pick;
          end
        end else begin
          c.action    = action_e'($urandom_range(0, 1));
          c.requester = 3'($urandom_range(0, 7));
        end
        issue(c, 1'b0, none);
      end
    end

    // Drain: let every owed result arrive, then a few cycles more so a stray
    // extra strobe would still be seen.
    start <= 1'b0;
    guard = 0;
    while (pending_grants.size() != 0 && guard < 40 * REQUESTERS) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (REQUESTERS + 2) @(negedge clk_i);
    if (pending_grants.size() != 0) begin
      errors += pending_grants.size();
      $display("ERROR: %0d results never arrived", pending_grants.size());
    end

    $display("Covered %0d requests (%0d refused) and %0d releases under %0d label limits.",
             n_request, n_refused, n_release, n_settings);
    $display("Checked %0d results: %0d mismatches, %0d failures in all.",
             results_seen, mismatches, errors);
    if (errors == 0) begin
      $display("** bakery_ticket_lock_arbiter: PASSED **");
    end else begin
      $display("** bakery_ticket_lock_arbiter: FAILED **");
    end
    $finish;
  end

endmodule
